// File: design/sphk_pkg.sv
`default_nettype none
package sphk_pkg;
   localparam int DIST_W  = 24;
   localparam int H_W     = 24;
   localparam int SIGMA_W = 32;
   localparam int VALUE_W = 32;
   localparam int GRAD_W  = 48;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam int VNUM_W = 105;
   localparam int GNUM_W = 115;
   localparam int VDEN_W = 72;
   localparam int GDEN_W = 96;
   localparam int QUO_W  = 48;

   localparam logic [H_W-1:0]     H_RESET     = 24'd65536;
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 32'd166886;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_NORM       = 1'b1;

   localparam logic [GRAD_W-1:0] GRAD_SAT = 48'h8000_0000_0000;

   typedef struct packed {
      logic sup;
      logic lo;
      logic rz;
   } flags_type;
endpackage
`default_nettype wire

// File: design/sphk_if.sv
`default_nettype none
interface sphk_req_if;
   import sphk_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

interface sphk_rsp_if;
   import sphk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [VALUE_W-1:0]       kernel_value;
   logic signed [GRAD_W-1:0] grad_factor;
   logic                     in_support;
   modport source (output valid, output kernel_value, output grad_factor,
                    output in_support, input ready);
   modport sink   (input valid, input kernel_value, input grad_factor,
                    input in_support, output ready);
endinterface
`default_nettype wire

// File: design/sph_cubic_kernel_eval_3d.sv
// 3D cubic spline SPH kernel evaluator.
// req_chan (sink): one transaction carries a distance r, unsigned Q8.16.
// rsp_chan (source): one transaction per request with kernel_value (Q16.16),
//   grad_factor (signed Q32.16, never positive) and in_support, in request order.
// csr_*: write smoothing_length (index 0) or sigma_norm (index 1) while idle.
// Throughput: one transaction per cycle unless rsp_chan stalls. From request
//   acceptance to response valid a request passes six arithmetic stages, a 48-stage
//   restoring divider pair (one quotient bit per stage) and the output register.
// The whole pipeline advances together; when rsp_chan is stalled with a
//   response pending, req_chan.ready drops and every stage holds.
// Reset clears all valid bits and loads the register defaults
//   (h = 1.0, sigma = 166886 raw); nothing else needs clearing.
// Outside support both results are zero; at r = 0 the gradient is zero.
`default_nettype none
module sph_cubic_kernel_eval_3d
   import sphk_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   sphk_req_if.sink                  req_chan,
   sphk_rsp_if.source                rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);
   logic [H_W-1:0]     h_ff;
   logic [SIGMA_W-1:0] sigma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= H_RESET;
         sigma_ff <= SIGMA_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTHING_LENGTH: h_ff <= csr_wdata[H_W-1:0];
            CSR_SIGMA_NORM:       sigma_ff <= csr_wdata[SIGMA_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   logic [5:0] v_ff;
   logic [QUO_W-1:0] vq_ff;

   // stage 1
   logic [23:0] r1_ff, h1_ff;
   logic [31:0] s1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= req_chan.distance;
         h1_ff <= h_ff;
         s1_ff <= sigma_ff;
      end
   end

   // stage 2
   flags_type   f1, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [23:0] d1, r2_ff, h2_ff, d2_ff;
   logic [24:0] g1, g2_ff;
   logic [34:0] a1, a2_ff;
   logic [31:0] s2_ff;
   logic [47:0] hh2_ff, rr2_ff, dd2_ff;
   assign f1.sup = (r1_ff < h1_ff);
   assign f1.lo  = ({r1_ff, 1'b0} < {1'b0, h1_ff});
   assign f1.rz  = (r1_ff == '0);
   assign d1 = h1_ff - r1_ff;
   assign g1 = {h1_ff, 1'b0} - ({1'b0, r1_ff} + {r1_ff, 1'b0});
   assign a1 = {1'b0, s1_ff, 2'b0} + {2'b0, s1_ff, 1'b0};
   always_ff @(posedge clock) begin
      if (en) begin
         f2_ff  <= f1;
         r2_ff  <= r1_ff;
         h2_ff  <= h1_ff;
         d2_ff  <= d1;
         g2_ff  <= g1;
         a2_ff  <= a1;
         s2_ff  <= s1_ff;
         hh2_ff <= 48'(h1_ff) * 48'(h1_ff);
         rr2_ff <= 48'(r1_ff) * 48'(r1_ff);
         dd2_ff <= 48'(d1) * 48'(d1);
      end
   end

   // stage 3
   logic [23:0] r3_ff;
   logic [31:0] s3_ff;
   logic [71:0] h3_3_ff, t3_ff, d3_3_ff;
   logic [59:0] ga3_ff;
   logic [58:0] gbl3_ff, gbh3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         f3_ff   <= f2_ff;
         r3_ff   <= r2_ff;
         s3_ff   <= s2_ff;
         h3_3_ff <= 72'(hh2_ff) * 72'(h2_ff);
         t3_ff   <= 72'(rr2_ff) * 72'(d2_ff);
         d3_3_ff <= 72'(dd2_ff) * 72'(d2_ff);
         ga3_ff  <= 60'(a2_ff) * 60'(g2_ff);
         gbl3_ff <= 59'(a2_ff) * 59'(dd2_ff[23:0]);
         gbh3_ff <= 59'(a2_ff) * 59'(dd2_ff[47:24]);
      end
   end

   // stage 4
   logic [71:0] p3, vb3, vb4_ff, h3_4_ff;
   logic [32:0] vm3, vm4_ff;
   logic [82:0] gn3, gn4_ff;
   logic [59:0] hrl4_ff, hrh4_ff;
   assign p3  = h3_3_ff - ({t3_ff[69:0], 2'b0} + {t3_ff[70:0], 1'b0});
   assign vb3 = f3_ff.lo ? p3 : d3_3_ff;
   assign vm3 = f3_ff.lo ? {1'b0, s3_ff} : {s3_ff, 1'b0};
   assign gn3 = f3_ff.lo ? 83'(ga3_ff) : ({gbh3_ff, 24'b0} + 83'(gbl3_ff));
   always_ff @(posedge clock) begin
      if (en) begin
         f4_ff   <= f3_ff;
         vb4_ff  <= vb3;
         vm4_ff  <= vm3;
         gn4_ff  <= gn3;
         h3_4_ff <= h3_3_ff;
         hrl4_ff <= 60'(h3_3_ff[35:0]) * 60'(r3_ff);
         hrh4_ff <= 60'(h3_3_ff[71:36]) * 60'(r3_ff);
      end
   end

   // stage 5
   logic [68:0] vpl5_ff, vph5_ff;
   logic [82:0] gn5_ff;
   logic [71:0] h3_5_ff;
   logic [95:0] gd4, gd5_ff;
   assign gd4 = f4_ff.lo ? 96'(h3_4_ff) : ({hrh4_ff, 36'b0} + 96'(hrl4_ff));
   always_ff @(posedge clock) begin
      if (en) begin
         f5_ff   <= f4_ff;
         vpl5_ff <= 69'(vb4_ff[35:0]) * 69'(vm4_ff);
         vph5_ff <= 69'(vb4_ff[71:36]) * 69'(vm4_ff);
         gn5_ff  <= gn4_ff;
         h3_5_ff <= h3_4_ff;
         gd5_ff  <= gd4;
      end
   end

   // stage 6
   logic [VNUM_W-1:0] vn6_ff;
   logic [GNUM_W-1:0] gn6_ff;
   logic [VDEN_W-1:0] vd6_ff;
   logic [GDEN_W-1:0] gd6_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         f6_ff  <= f5_ff;
         vn6_ff <= {vph5_ff, 36'b0} + VNUM_W'(vpl5_ff);
         gn6_ff <= {gn5_ff, 32'b0};
         vd6_ff <= h3_5_ff;
         gd6_ff <= gd5_ff;
      end
   end

   logic [QUO_W-1:0] vq, gq;
   logic             vovf, govf;

   sphk_div_pipe #(.NW(VNUM_W), .DW(VDEN_W), .QW(QUO_W)) u_value_div (
      .clock (clock), .en (en), .num (vn6_ff), .den (vd6_ff),
      .quo (vq), .ovf (vovf)
   );

   sphk_div_pipe #(.NW(GNUM_W), .DW(GDEN_W), .QW(QUO_W)) u_grad_div (
      .clock (clock), .en (en), .num (gn6_ff), .den (gd6_ff),
      .quo (gq), .ovf (govf)
   );

   flags_type fq_ff [QUO_W];
   always_ff @(posedge clock) begin
      if (en) begin
         fq_ff[0] <= f6_ff;
         for (int k = 1; k < QUO_W; k++) begin
            fq_ff[k] <= fq_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         vq_ff <= '0;
      end else if (en) begin
         v_ff  <= {v_ff[4:0], req_chan.valid};
         vq_ff <= {vq_ff[QUO_W-2:0], v_ff[5]};
      end
   end

   flags_type          fo;
   logic [VALUE_W-1:0] val_in, val_ff;
   logic [GRAD_W-1:0]  mag, grad_in, grad_ff;
   logic               sup_ff;
   assign fo  = fq_ff[QUO_W-1];
   assign mag = (govf || gq > GRAD_SAT) ? GRAD_SAT : gq;
   always_comb begin
      val_in  = '0;
      grad_in = '0;
      if (fo.sup) begin
         val_in = (vovf || vq[QUO_W-1:VALUE_W] != '0) ? '1 : vq[VALUE_W-1:0];
         if (!(fo.lo && fo.rz)) begin
            grad_in = '0 - mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vq_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= val_in;
         grad_ff <= grad_in;
         sup_ff  <= fo.sup;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kernel_value = val_ff;
   assign rsp_chan.grad_factor  = grad_ff;
   assign rsp_chan.in_support   = sup_ff;
endmodule
`default_nettype wire

// File: design/sphk_div_pipe.sv
`default_nettype none
module sphk_div_pipe
   import sphk_pkg::*;
#(
   parameter int NW = GNUM_W,
   parameter int DW = GDEN_W,
   parameter int QW = QUO_W
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic [QW-1:0]      quo,
   output logic               ovf
);
   localparam int RW = DW + 1;

   logic [RW-1:0] rem_ff [QW];
   logic [QW-1:0] nlo_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] ovf_ff;

   logic [NW-1:0] num_hi;
   assign num_hi = num >> QW;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW-1:0] rp, sh, rem_in;
      logic [QW-1:0] np, qp;
      logic [DW-1:0] dp;
      logic          op, ge;
      if (k == 0) begin : g_first
         assign rp = RW'(num_hi);
         assign np = num[QW-1:0];
         assign qp = '0;
         assign dp = den;
         assign op = (num_hi >= NW'(den));
      end else begin : g_next
         assign rp = rem_ff[k-1];
         assign np = nlo_ff[k-1];
         assign qp = q_ff[k-1];
         assign dp = d_ff[k-1];
         assign op = ovf_ff[k-1];
      end
      assign sh     = {rp[RW-2:0], np[QW-1]};
      assign ge     = (sh >= {1'b0, dp});
      assign rem_in = ge ? (sh - {1'b0, dp}) : sh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nlo_ff[k] <= {np[QW-2:0], 1'b0};
            q_ff[k]   <= {qp[QW-2:0], ge};
            d_ff[k]   <= dp;
            ovf_ff[k] <= op;
         end
      end
   end

   assign quo = q_ff[QW-1];
   assign ovf = ovf_ff[QW-1];
endmodule
`default_nettype wire
